// ===== hw/rtl/pwfr_pkg.sv =====
// pwfr_pkg: shared types and constants of the pulse width frame receiver
// no dependencies; imported by every module of the block
package pwfr_pkg;

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned RAW_W = 16;
  localparam int unsigned WIDTH_W = 8;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned FRAME_W = 64;
  localparam int unsigned BYTE_W = 8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAP_MIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAP_MAX = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_THRESHOLD = 2'd3;

  // configuration reset values
  localparam logic [WIDTH_W-1:0] RST_SYNC_WIDTH = 8'd12;
  localparam logic [WIDTH_W-1:0] RST_GAP_MIN = 8'd8;
  localparam logic [WIDTH_W-1:0] RST_GAP_MAX = 8'd10;
  localparam logic [WIDTH_W-1:0] RST_ONE_THRESHOLD = 8'd5;

  // result status codes
  localparam logic [STATUS_W-1:0] STATUS_NONE = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_GOOD = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_CSUM_ERR = 2'd2;

  typedef struct packed {
    logic [WIDTH_W-1:0] sync_width;
    logic [WIDTH_W-1:0] gap_min;
    logic [WIDTH_W-1:0] gap_max;
    logic [WIDTH_W-1:0] one_threshold;
  } pwfr_cfg_t;

  // classification of one halved pulse width
  typedef struct packed {
    logic is_sync;
    logic is_gap;
    logic is_one;
  } pulse_cls_t;

endpackage

// ===== hw/rtl/pulse_width_frame_receiver_unit.sv =====
// pulse_width_frame_receiver_unit: top level of the pulse width frame receiver
// depends on pwfr_pkg, pwfr_front, pwfr_queue, pwfr_back
//
//  port group  direction  transaction
//  in_*        input      one captured pulse width (valid/ready)
//  out_*       output     one status + frame word per pulse (valid/ready)
//  cfg_*       input      register write, taken whenever cfg_we is high
//
// one pulse per cycle sustained while out_ready stays high; each taken pulse's
// class is queued, then popped into the output register, which offers the
// result; a low out_ready leaves classes waiting in the queue
// rst_n is synchronous: receiver waits for sync, registers take defaults
// the two-entry queue lets the front take pulses on a low out_ready until full
module pulse_width_frame_receiver_unit
  import pwfr_pkg::*;
#(
  parameter int unsigned FRAME_LEN = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [RAW_W-1:0]      in_raw_width,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [STATUS_W-1:0]   out_status,
  output logic [FRAME_W-1:0]    out_frame_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  pwfr_cfg_t  cfg_r;
  pulse_cls_t front_cls;
  pulse_cls_t q_data;
  logic       q_full;
  logic       q_not_empty;
  logic       q_pop;
  logic       in_take;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sync_width    <= RST_SYNC_WIDTH;
      cfg_r.gap_min       <= RST_GAP_MIN;
      cfg_r.gap_max       <= RST_GAP_MAX;
      cfg_r.one_threshold <= RST_ONE_THRESHOLD;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SYNC_WIDTH:    cfg_r.sync_width    <= cfg_wdata;
        REG_GAP_MIN:       cfg_r.gap_min       <= cfg_wdata;
        REG_GAP_MAX:       cfg_r.gap_max       <= cfg_wdata;
        REG_ONE_THRESHOLD: cfg_r.one_threshold <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // front takes a pulse whenever the queue has room
  assign in_ready = !q_full;
  assign in_take  = in_valid && in_ready;

  pwfr_front u_front (
    .raw_width (in_raw_width),
    .cfg       (cfg_r),
    .cls       (front_cls)
  );

  pwfr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_take),
    .push_data (front_cls),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_data  (q_data)
  );

  // back pops one class per cycle while its output register can take a result
  pwfr_back #(
    .FRAME_LEN (FRAME_LEN)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_not_empty    (q_not_empty),
    .q_data         (q_data),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_frame_data (out_frame_data)
  );

endmodule

// ===== hw/rtl/pwfr_front.sv =====
// pwfr_front: halves each captured width with rounding and classifies it
// depends on pwfr_pkg
module pwfr_front
  import pwfr_pkg::*;
(
  input  logic [RAW_W-1:0] raw_width,
  input  pwfr_cfg_t        cfg,
  output pulse_cls_t       cls
);

  logic [8:0]         inc;
  logic [WIDTH_W-1:0] halved;

  // bits 8..1 of raw+1 only depend on the low nine raw bits
  assign inc    = raw_width[8:0] + 9'd1;
  assign halved = inc[8:1];

  assign cls.is_sync = (halved == cfg.sync_width);
  assign cls.is_gap  = (halved >= cfg.gap_min) && (halved <= cfg.gap_max);
  assign cls.is_one  = (halved > cfg.one_threshold);

endmodule

// ===== hw/rtl/pwfr_queue.sv =====
// pwfr_queue: two-entry queue of pulse classes between front and back
// depends on pwfr_pkg
module pwfr_queue
  import pwfr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  pulse_cls_t push_data,
  output logic       full,
  input  logic       pop,
  output logic       not_empty,
  output pulse_cls_t pop_data
);

  pulse_cls_t mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign pop_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== hw/rtl/pwfr_back.sv =====
// pwfr_back: sync/gap/data receiver, frame assembly, checksum, output register
// depends on pwfr_pkg
module pwfr_back
  import pwfr_pkg::*;
#(
  parameter int unsigned FRAME_LEN = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_not_empty,
  input  pulse_cls_t          q_data,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATUS_W-1:0] out_status,
  output logic [FRAME_W-1:0]  out_frame_data
);

  localparam int unsigned BC_W = $clog2(FRAME_LEN);
  localparam logic [BC_W-1:0] LAST_BYTE = BC_W'(FRAME_LEN - 1);

  localparam logic [1:0] PH_SYNC = 2'd0;
  localparam logic [1:0] PH_GAP  = 2'd1;
  localparam logic [1:0] PH_DATA = 2'd2;

  logic [1:0]          phase_r, phase_nxt;
  logic [2:0]          bit_cnt_r, bit_cnt_nxt;
  logic [BC_W-1:0]     byte_cnt_r, byte_cnt_nxt;
  logic [BYTE_W-1:0]   shift_r, shift_nxt;
  logic [BYTE_W-1:0]   sum_r, sum_nxt;
  logic [BYTE_W-1:0]   frame_r [FRAME_LEN-1];
  logic [BYTE_W-1:0]   new_byte;
  logic                byte_done;
  logic                store_byte;
  logic                frame_done;
  logic [FRAME_W-1:0]  data_nxt;
  logic [STATUS_W-1:0] status_nxt;
  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [FRAME_W-1:0]  out_frame_data_r;

  assign q_pop     = q_not_empty && (!out_valid_r || out_ready);
  assign new_byte  = q_data.is_one ? (shift_r | (8'h80 >> bit_cnt_r)) : shift_r;
  assign byte_done = (phase_r == PH_DATA) && (bit_cnt_r == 3'd7);
  assign frame_done = byte_done && (byte_cnt_r == LAST_BYTE);
  assign store_byte = byte_done && !frame_done;

  always_comb begin
    phase_nxt    = phase_r;
    bit_cnt_nxt  = bit_cnt_r;
    byte_cnt_nxt = byte_cnt_r;
    shift_nxt    = shift_r;
    sum_nxt      = sum_r;
    unique case (phase_r)
      PH_GAP: begin
        phase_nxt = q_data.is_gap ? PH_DATA : PH_SYNC;
      end
      PH_DATA: begin
        bit_cnt_nxt = bit_cnt_r + 3'd1;
        shift_nxt   = new_byte;
        if (byte_done) begin
          shift_nxt = '0;
          if (frame_done) begin
            phase_nxt    = PH_SYNC;
            byte_cnt_nxt = '0;
          end else begin
            byte_cnt_nxt = byte_cnt_r + BC_W'(1);
            sum_nxt      = sum_r + new_byte;
          end
        end
      end
      default: begin
        // sync hunt; the unused phase code behaves the same
        bit_cnt_nxt  = '0;
        byte_cnt_nxt = '0;
        shift_nxt    = '0;
        sum_nxt      = '0;
        phase_nxt    = q_data.is_sync ? PH_GAP : PH_SYNC;
      end
    endcase
  end

  // frame word, zero if no frame completes: stored bytes, the last byte straight from assembly, zero past the frame
  always_comb begin
    data_nxt = '0;
    for (int k = 0; k < FRAME_LEN - 1; k++) begin
      data_nxt[(7-k)*8 +: 8] = frame_r[k];
    end
    data_nxt[(8-FRAME_LEN)*8 +: 8] = new_byte;
    if (!frame_done) begin
      data_nxt   = '0;
      status_nxt = STATUS_NONE;
    end else if (sum_r == new_byte) begin
      status_nxt = STATUS_GOOD;
    end else begin
      status_nxt = STATUS_CSUM_ERR;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < FRAME_LEN - 1; k++) begin
      if (q_pop && store_byte && (byte_cnt_r == BC_W'(k))) begin
        frame_r[k] <= new_byte;
      end
    end
    if (q_pop) begin
      out_status_r     <= status_nxt;
      out_frame_data_r <= data_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_SYNC;
      bit_cnt_r   <= '0;
      byte_cnt_r  <= '0;
      shift_r     <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        phase_r    <= phase_nxt;
        bit_cnt_r  <= bit_cnt_nxt;
        byte_cnt_r <= byte_cnt_nxt;
        shift_r    <= shift_nxt;
        sum_r      <= sum_nxt;
      end
      if (q_pop) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_frame_data = out_frame_data_r;

endmodule

// ===== bench/pwfr_checker.sv =====
`timescale 1ns / 100ps
// pwfr_checker: watches the pulse, result and register ports of the frame receiver,
// predicts status and frame word per pulse and compares; depends on pwfr_pkg
module pwfr_checker
  import pwfr_pkg::*;
#(
  parameter int unsigned FRAME_LEN = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [RAW_W-1:0]      in_raw_width,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [STATUS_W-1:0]   out_status,
  input  logic [FRAME_W-1:0]    out_frame_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    mismatch_count,
  output int                    due_count
);

  typedef enum logic [1:0] {
    HUNT_SYNC = 2'd0,
    CHECK_GAP = 2'd1,
    TAKE_BITS = 2'd2
  } rx_phase_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [FRAME_W-1:0]  frame;
  } frame_result_t;

  pwfr_cfg_t          regs;
  rx_phase_t          rx_phase;
  logic [2:0]         bit_idx;
  int                 byte_idx;
  logic [BYTE_W-1:0]  cur_byte;
  logic [BYTE_W-1:0]  rx_bytes [8];
  frame_result_t      frames_due [$];
  int                 mismatches = 0;

  task automatic decode_pulse(input logic [RAW_W-1:0] raw, output frame_result_t res);
    logic [RAW_W:0]     rounded;
    logic [WIDTH_W-1:0] w;
    logic [BYTE_W-1:0]  csum;
    int                 k;
    rounded = {1'b0, raw} + 1'b1;
    w = rounded[WIDTH_W:1];
    res.status = STATUS_NONE;
    res.frame = '0;
    case (rx_phase)
      CHECK_GAP: begin
        rx_phase = (w >= regs.gap_min && w <= regs.gap_max) ? TAKE_BITS : HUNT_SYNC;
      end
      TAKE_BITS: begin
        // msb first
        if (w > regs.one_threshold) cur_byte[3'd7 - bit_idx] = 1'b1;
        bit_idx = bit_idx + 3'd1;
        if (bit_idx == 3'd0) begin
          rx_bytes[byte_idx] = cur_byte;
          byte_idx = byte_idx + 1;
          if (byte_idx >= FRAME_LEN) begin
            csum = '0;
            for (k = 0; k + 1 < FRAME_LEN; k++) csum = csum + rx_bytes[k];
            for (k = 0; k < FRAME_LEN; k++) res.frame[(7 - k) * 8 +: 8] = rx_bytes[k];
            res.status = (csum == rx_bytes[FRAME_LEN-1]) ? STATUS_GOOD : STATUS_CSUM_ERR;
            rx_phase = HUNT_SYNC;
            byte_idx = 0;
          end
          cur_byte = '0;
        end
      end
      default: begin
        // unused phase behaves as the sync hunt
        bit_idx = '0;
        byte_idx = 0;
        cur_byte = '0;
        rx_phase = (w == regs.sync_width) ? CHECK_GAP : HUNT_SYNC;
      end
    endcase
  endtask

  always @(posedge clk) begin
    frame_result_t res;
    frame_result_t due;
    if (!rst_n) begin
      regs.sync_width = RST_SYNC_WIDTH;
      regs.gap_min = RST_GAP_MIN;
      regs.gap_max = RST_GAP_MAX;
      regs.one_threshold = RST_ONE_THRESHOLD;
      rx_phase = HUNT_SYNC;
      bit_idx = '0;
      byte_idx = 0;
      cur_byte = '0;
      frames_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SYNC_WIDTH:    regs.sync_width = cfg_wdata;
          REG_GAP_MIN:       regs.gap_min = cfg_wdata;
          REG_GAP_MAX:       regs.gap_max = cfg_wdata;
          REG_ONE_THRESHOLD: regs.one_threshold = cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (frames_due.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none, actual status %0d frame %h",
                   $time, out_status, out_frame_data);
        end else begin
          due = frames_due.pop_front();
          if (out_status !== due.status) begin
            mismatches++;
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, due.status, out_status);
          end
          if (out_frame_data !== due.frame) begin
            mismatches++;
            $display("%0t: frame_data mismatch, expected %h, actual %h",
                     $time, due.frame, out_frame_data);
          end
        end
      end
      if (in_valid && in_ready) begin
        decode_pulse(in_raw_width, res);
        frames_due.push_back(res);
      end
    end
    mismatch_count <= mismatches;
    due_count <= frames_due.size();
  end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// tb_top: stimulus and verdict for pulse_width_frame_receiver_unit
// depends on pwfr_pkg, the receiver rtl and pwfr_checker
module tb_top
  import pwfr_pkg::*;
();

  localparam int unsigned FRAME_LEN = 8;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [RAW_W-1:0]      in_raw_width = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [STATUS_W-1:0]   out_status;
  logic [FRAME_W-1:0]    out_frame_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  int mismatch_total;
  int frames_pending;

  // stimulus-side copy of the register values, used only to shape pulses
  logic [WIDTH_W-1:0] cur_sync = RST_SYNC_WIDTH;
  logic [WIDTH_W-1:0] cur_gmin = RST_GAP_MIN;
  logic [WIDTH_W-1:0] cur_gmax = RST_GAP_MAX;
  logic [WIDTH_W-1:0] cur_thr = RST_ONE_THRESHOLD;

  int pulses_sent = 0;
  int burst_left = 0;

  always #5 clk = ~clk;

  pulse_width_frame_receiver_unit #(
    .FRAME_LEN(FRAME_LEN)
  ) uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_raw_width  (in_raw_width),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_status    (out_status),
    .out_frame_data(out_frame_data),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  pwfr_checker #(
    .FRAME_LEN(FRAME_LEN)
  ) checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_raw_width  (in_raw_width),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_status    (out_status),
    .out_frame_data(out_frame_data),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .mismatch_count(mismatch_total),
    .due_count     (frames_pending)
  );

  // pick a raw tick count that halves to w: random upper bits (lost in the
  // 8-bit truncation) and a random rounding bit, so every raw bit toggles;
  // w of 0 with the rounding bit set and zero upper bits wraps to the all-ones raw width
  function automatic logic [RAW_W-1:0] width_to_raw(input logic [WIDTH_W-1:0] w);
    logic [14:0]      v;
    logic [RAW_W-1:0] dbl;
    v = {7'($urandom_range(127, 0)), w};
    dbl = {v, 1'b0};
    return dbl - RAW_W'($urandom_range(1, 0));
  endfunction

  // one pulse transaction; the sender runs in bursts, some with idle gaps between,
  // and valid stays high across back-to-back transactions
  task automatic push_width(input logic [RAW_W-1:0] raw);
    int idle;
    if (burst_left == 0) begin
      burst_left = $urandom_range(24, 1);
      idle = ($urandom_range(1, 0) == 0) ? 0 : $urandom_range(6, 1);
      if (idle > 0) begin
        in_valid <= 1'b0;
        repeat (idle) @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_raw_width <= raw;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
    pulses_sent++;
  endtask

  // stop offering pulses and wait for every predicted result, then let the
  // queue and output register settle before touching registers
  task automatic drain_results();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (frames_pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apply_settings(input logic [7:0] s, input logic [7:0] gl,
                                input logic [7:0] gh, input logic [7:0] th);
    drain_results();
    cfg_we <= 1'b1;
    cfg_index <= REG_SYNC_WIDTH;
    cfg_wdata <= s;
    @(posedge clk);
    cfg_index <= REG_GAP_MIN;
    cfg_wdata <= gl;
    @(posedge clk);
    cfg_index <= REG_GAP_MAX;
    cfg_wdata <= gh;
    @(posedge clk);
    cfg_index <= REG_ONE_THRESHOLD;
    cfg_wdata <= th;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_sync = s;
    cur_gmin = gl;
    cur_gmax = gh;
    cur_thr = th;
  endtask

  // sync, gap, then FRAME_LEN bytes msb first; last byte is the sum of the
  // others for a good frame, off by a nonzero amount otherwise
  task automatic send_frame(input bit good);
    logic [7:0]         fb [8];
    logic [7:0]         csum;
    logic [WIDTH_W-1:0] w;
    int                 b;
    int                 i;
    csum = '0;
    for (b = 0; b + 1 < FRAME_LEN; b++) begin
      fb[b] = 8'($urandom);
      csum = csum + fb[b];
    end
    fb[FRAME_LEN-1] = good ? csum : csum + 8'($urandom_range(255, 1));
    push_width(width_to_raw(cur_sync));
    if (cur_gmin <= cur_gmax) begin
      case ($urandom_range(3, 0))
        0:       w = cur_gmin;
        1:       w = cur_gmax;
        default: w = 8'($urandom_range(cur_gmax, cur_gmin));
      endcase
    end else begin
      // empty window: whatever comes, the receiver falls back to sync hunt
      w = 8'($urandom);
    end
    push_width(width_to_raw(w));
    for (b = 0; b < FRAME_LEN; b++) begin
      for (i = 7; i >= 0; i--) begin
        // a threshold of all ones leaves no width that decodes as a one
        if (fb[b][i] && cur_thr != 8'hFF) begin
          w = ($urandom_range(3, 0) == 0) ? cur_thr + 8'd1
                                           : 8'($urandom_range(255, cur_thr + 1));
        end else begin
          w = ($urandom_range(3, 0) == 0) ? cur_thr : 8'($urandom_range(cur_thr, 0));
        end
        push_width(width_to_raw(w));
      end
    end
  endtask

  // pulses that never match the sync width, so a receiver in hunt stays there
  task automatic send_noise(input int count);
    logic [WIDTH_W-1:0] w;
    int                 n;
    for (n = 0; n < count; n++) begin
      w = 8'($urandom);
      if (w == cur_sync) w = w + 8'd1;
      push_width(width_to_raw(w));
    end
  endtask

  // sync followed by a gap outside the window; skipped when the window
  // covers every width
  task automatic send_bad_gap();
    logic [WIDTH_W-1:0] w;
    if (cur_gmin > cur_gmax) begin
      w = 8'($urandom);
    end else if (cur_gmin == 8'd0 && cur_gmax == 8'hFF) begin
      return;
    end else if (cur_gmin != 8'd0 && (cur_gmax == 8'hFF || $urandom_range(1, 0) == 0)) begin
      w = 8'($urandom_range(cur_gmin - 1, 0));
    end else begin
      w = 8'($urandom_range(255, cur_gmax + 1));
    end
    push_width(width_to_raw(cur_sync));
    push_width(width_to_raw(w));
  endtask

  // mostly well-formed frames with random content, the rest noise and
  // broken sync/gap pairs
  task automatic run_traffic(input int budget);
    int start;
    start = pulses_sent;
    while (pulses_sent - start < budget) begin
      case ($urandom_range(9, 0))
        0, 1, 2, 3, 4, 5: send_frame($urandom_range(2, 0) != 0);
        6, 7:             send_noise($urandom_range(8, 1));
        default:          send_bad_gap();
      endcase
    end
  endtask

  // receiver: random stall pattern, with a long hold-off every 16th segment
  // (the first right after reset) so the block backs up and drops in_ready
  initial begin
    int seg;
    int len;
    int n;
    seg = 0;
    wait (rst_n);
    forever begin
      seg++;
      if (seg % 16 == 1) begin
        out_ready <= 1'b0;
        len = $urandom_range(80, 40);
        repeat (len) @(posedge clk);
      end else begin
        len = $urandom_range(30, 1);
        case ($urandom_range(2, 0))
          0: begin
            for (n = 0; n < len; n++) begin
              out_ready <= 1'b1;
              @(posedge clk);
            end
          end
          1: begin
            for (n = 0; n < len; n++) begin
              out_ready <= 1'($urandom_range(1, 0));
              @(posedge clk);
            end
          end
          default: begin
            for (n = 0; n < len % 7; n++) begin
              out_ready <= 1'b0;
              @(posedge clk);
            end
          end
        endcase
      end
    end
  end

  // main sequence
  initial begin
    logic [7:0] gl;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed, reset register values (sync 12, gap 8..10, threshold 5)
    push_width(16'h0000);
    push_width(16'hFFFF);    // halving overflow, low bits zero
    push_width(16'h0001);
    push_width(16'hFFFE);
    push_width(16'h8000);
    push_width(16'h7FFF);
    push_width(16'hAAAA);
    push_width(16'h5555);
    push_width(16'd24);      // sync, then a gap one below the window
    push_width(16'd14);
    push_width(16'd23);      // sync via the rounding bit, gap one above
    push_width(16'd22);
    push_width(16'd536);     // sync with upper bits set, gap far too wide
    push_width(16'd510);
    send_frame(1'b1);
    send_frame(1'b0);
    run_traffic(50);

    // low extremes: sync and gap at zero, any nonzero width is a one
    apply_settings(8'd0, 8'd0, 8'd0, 8'd0);
    run_traffic(80);

    // high extremes: only the widest pulse decodes as a one
    apply_settings(8'hFF, 8'hFF, 8'hFF, 8'hFE);
    run_traffic(80);

    // full gap window, no width can decode as a one
    apply_settings(8'hFF, 8'd0, 8'hFF, 8'hFF);
    run_traffic(60);

    // empty gap window: frames never start
    apply_settings(8'($urandom), 8'd200, 8'd100, 8'($urandom));
    run_traffic(50);

    repeat (2) begin
      gl = 8'($urandom_range(200, 0));
      apply_settings(8'($urandom), gl, 8'($urandom_range(255, gl)), 8'($urandom));
      run_traffic(80);
    end

    drain_results();
    repeat (10) @(posedge clk);
    if (mismatch_total == 0 && frames_pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // hang guard
  initial begin
    #3_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
